>>> rtl/pcl_pkg.sv
`timescale 1ns / 1ps

package pcl_pkg;

    // Operation codes carried on the input side.
    localparam logic [1:0] FUNC_OPEN  = 2'd0;
    localparam logic [1:0] FUNC_CLOSE = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REFUSED   = 3'd1;
    localparam logic [2:0] ST_NIL       = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 16;

    // One table slot as it is held in the table memory.
    typedef struct packed {
        logic                 valid;
        logic [ADDR_W-1:0]    addr;
        logic [COUNT_W-1:0]   count;
    } t_entry;

    // One finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic                 over_limit;
        logic [COUNT_W-1:0]   conn_count;
        logic [2:0]           status;
    } t_result;

endpackage

>>> rtl/per_source_connection_limiter_top.sv
`timescale 1ns / 1ps
// Per-source connection limiter. Each input beat on the s_axis channel carries an
// operation in tuser (open, close or query) and an IPv4 source address in tdata.
// The block keeps a table of TABLE_ENTRIES addresses with a live connection count
// each, and answers every input beat with exactly one result beat on m_axis: a
// status and an over-limit flag in tuser and the resulting count in tdata.
// The user must see that the limit is written through i_cfg_wr_en / i_cfg_wr_data
// while the block is idle; the block does not enforce this. After reset the table
// memory is cleared one slot per cycle; s_axis tready stays low during that pass.
// An item is handled by a sequencer that sweeps the table memory through its
// single read port, one slot per cycle, with one address compare per slot. The
// sweep stops early when the address is found, and the nil address skips it.
// The block takes one item at a time; tready returns high once the result has
// been moved into the output register. The output register holds one result, so
// the next item can be accepted while that result waits; if the receiver stalls
// longer, the sequencer holds its finished result and the table update until the
// register is free again.
module per_source_connection_limiter_top #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] source_address
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] conn_count
    output logic [3:0]  o_m_axis_tuser,   // [2:0] status, [3] over_limit
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data     // max_per_source
);

    import pcl_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [15:0] r_max;
    logic        r_out_valid;
    t_result     r_out;

    logic        res_valid;
    logic        res_ready;
    t_result     res;

    logic        ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    t_entry      ram_wdata;
    t_entry      ram_rdata;

    // The output register can take a result when empty or when it drains now.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    pcl_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_func      (i_s_axis_tuser),
        .i_addr      (i_s_axis_tdata),
        .i_max       (r_max),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

    // Table memory: one valid bit, the address and its count per slot.
    pcl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Write the limit register only while no item is in flight; it is unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (i_cfg_wr_en) begin
            r_max <= i_cfg_wr_data;
        end
    end

    // Output register: loads a result whenever the sequencer offers one and
    // there is room, otherwise empties when the receiver takes the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.conn_count;
    assign o_m_axis_tuser  = {r_out.over_limit, r_out.status};

endmodule

>>> rtl/pcl_ram.sv
`timescale 1ns / 1ps

module pcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pcl_ctrl.sv
`timescale 1ns / 1ps

module pcl_ctrl #(
    parameter int TABLE_ENTRIES = 64,
    parameter int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  logic [1:0]            i_func,
    input  logic [31:0]           i_addr,
    input  logic [15:0]           i_max,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output pcl_pkg::t_result      o_res,
    output logic                  o_we,
    output logic [IW-1:0]         o_waddr,
    output pcl_pkg::t_entry       o_wdata,
    output logic [IW-1:0]         o_raddr,
    input  pcl_pkg::t_entry       i_rdata
);

    import pcl_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_chk_v, n_chk_v;
    logic [IW-1:0]       r_chk_idx, n_chk_idx;
    logic                r_hit, n_hit;
    logic [IW-1:0]       r_slot, n_slot;
    logic [COUNT_W-1:0]  r_slot_cnt, n_slot_cnt;
    logic                r_free_v, n_free_v;
    logic [IW-1:0]       r_free, n_free;
    logic [1:0]          r_func, n_func;
    logic [ADDR_W-1:0]   r_addr, n_addr;

    logic                upd_wr;
    t_entry              upd_entry;
    t_result             upd_res;

    // Outcome of the operation once the scan has settled hit and free slot.
    always_comb begin
        upd_wr         = 1'b0;
        upd_entry      = '0;
        upd_res.status = ST_OK;
        upd_res.conn_count = '0;
        if (r_addr == '0) begin
            upd_res.status = ST_NIL;
        end else if (r_hit) begin
            case (r_func)
                FUNC_OPEN: begin
                    if (r_slot_cnt >= i_max) begin
                        upd_res.status     = ST_REFUSED;
                        upd_res.conn_count = r_slot_cnt;
                    end else begin
                        upd_wr             = 1'b1;
                        upd_res.conn_count = r_slot_cnt + 16'd1;
                        upd_entry          = '{valid: 1'b1, addr: r_addr,
                                               count: r_slot_cnt + 16'd1};
                    end
                end
                FUNC_CLOSE: begin
                    upd_wr = 1'b1;
                    if (r_slot_cnt > 16'd1) begin
                        upd_res.conn_count = r_slot_cnt - 16'd1;
                        upd_entry          = '{valid: 1'b1, addr: r_addr,
                                               count: r_slot_cnt - 16'd1};
                    end
                end
                default: begin
                    upd_res.conn_count = r_slot_cnt;
                end
            endcase
        end else if (r_func == FUNC_OPEN) begin
            if (r_free_v) begin
                upd_wr             = 1'b1;
                upd_res.conn_count = 16'd1;
                upd_entry          = '{valid: 1'b1, addr: r_addr, count: 16'd1};
            end else begin
                upd_res.status = ST_FULL;
            end
        end else begin
            upd_res.status = ST_NOT_FOUND;
        end
        upd_res.over_limit = (upd_res.conn_count > i_max);
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_chk_v    = 1'b0;
        n_chk_idx  = r_chk_idx;
        n_hit      = r_hit;
        n_slot     = r_slot;
        n_slot_cnt = r_slot_cnt;
        n_free_v   = r_free_v;
        n_free     = r_free;
        n_func     = r_func;
        n_addr     = r_addr;
        o_we       = 1'b0;
        o_waddr    = r_cnt[IW-1:0];
        o_wdata    = '0;

        case (r_state)
            S_CLEAR: begin
                o_we = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    n_func   = i_func;
                    n_addr   = i_addr;
                    n_cnt    = '0;
                    n_hit    = 1'b0;
                    n_free_v = 1'b0;
                    n_state  = (i_addr == '0) ? S_UPDATE : S_SCAN;
                end
            end
            S_SCAN: begin
                // Read side: one slot address goes out each cycle.
                if (r_cnt != CNT_END) begin
                    n_chk_v   = 1'b1;
                    n_chk_idx = r_cnt[IW-1:0];
                    n_cnt     = r_cnt + CW'(1);
                end
                // Compare side: the slot read in the previous cycle.
                if (r_chk_v) begin
                    if (i_rdata.valid && (i_rdata.addr == r_addr)) begin
                        n_hit      = 1'b1;
                        n_slot     = r_chk_idx;
                        n_slot_cnt = i_rdata.count;
                        n_state    = S_UPDATE;
                    end else begin
                        if (!i_rdata.valid && !r_free_v) begin
                            n_free_v = 1'b1;
                            n_free   = r_chk_idx;
                        end
                        if (r_chk_idx == IDX_LAST) begin
                            n_state = S_UPDATE;
                        end
                    end
                end
            end
            S_UPDATE: begin
                if (i_res_ready) begin
                    o_we    = upd_wr;
                    o_waddr = r_hit ? r_slot : r_free;
                    o_wdata = upd_entry;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_chk_v  <= 1'b0;
            r_hit    <= 1'b0;
            r_free_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_chk_v  <= n_chk_v;
            r_hit    <= n_hit;
            r_free_v <= n_free_v;
        end
        r_chk_idx  <= n_chk_idx;
        r_slot     <= n_slot;
        r_slot_cnt <= n_slot_cnt;
        r_free     <= n_free;
        r_func     <= n_func;
        r_addr     <= n_addr;
    end

    assign o_s_ready   = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_UPDATE);
    assign o_res       = upd_res;
    assign o_raddr     = r_cnt[IW-1:0];

endmodule

>>> bench/tb_per_source_connection_limiter_top.sv
`timescale 1ns / 1ps

module tb_per_source_connection_limiter_top;

    import pcl_pkg::*;

    localparam int TABLE_SLOTS = 64;
    localparam logic [1:0] FUNC_SPARE = 2'd3;   // undefined code, treated as a query
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 16;
    localparam int POOL_MAX = 96;

    logic        clk;
    logic        rst_n;
    logic        in_tvalid;
    logic        in_tready;
    logic [31:0] in_tdata;
    logic [1:0]  in_tuser;
    logic        out_tvalid;
    logic        out_tready;
    logic [15:0] out_tdata;
    logic [3:0]  out_tuser;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    // Shadow of the block's table and limit register.
    logic                slot_valid [TABLE_SLOTS];
    logic [31:0]         slot_addr  [TABLE_SLOTS];
    logic [15:0]         slot_count [TABLE_SLOTS];
    logic [15:0]         limit_shadow;

    t_result     pending_results [$];
    int          error_count;
    int          quiet_cycles;
    bit          sender_idle_on;
    bit          receiver_idle_on;
    int          receiver_hold;
    int          receiver_burst;
    logic [31:0] addr_pool [POOL_MAX];

    per_source_connection_limiter_top #(
        .TABLE_ENTRIES(TABLE_SLOTS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .i_s_axis_tdata  (in_tdata),
        .i_s_axis_tuser  (in_tuser),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .o_m_axis_tdata  (out_tdata),
        .o_m_axis_tuser  (out_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Works out the result of one operation and applies it to the shadow table.
    function automatic t_result predict_conn_result(input logic [1:0] func,
                                                    input logic [31:0] addr);
        t_result res;
        int      hit;
        int      free_slot;
        res.status     = ST_OK;
        res.conn_count = '0;
        res.over_limit = 1'b0;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (hit < 0 && slot_valid[i] && slot_addr[i] == addr) hit = i;
            if (free_slot < 0 && !slot_valid[i]) free_slot = i;
        end
        if (addr == 32'd0) begin
            res.status = ST_NIL;
        end else if (func == FUNC_OPEN) begin
            if (hit < 0) begin
                if (free_slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    slot_valid[free_slot] = 1'b1;
                    slot_addr[free_slot]  = addr;
                    slot_count[free_slot] = 16'd1;
                    res.conn_count        = 16'd1;
                end
            end else if (slot_count[hit] >= limit_shadow) begin
                res.status     = ST_REFUSED;
                res.conn_count = slot_count[hit];
            end else begin
                slot_count[hit] = slot_count[hit] + 16'd1;
                res.conn_count  = slot_count[hit];
            end
        end else if (func == FUNC_CLOSE) begin
            if (hit < 0) begin
                res.status = ST_NOT_FOUND;
            end else if (slot_count[hit] <= 16'd1) begin
                // Closing the last connection frees the slot.
                slot_valid[hit] = 1'b0;
                slot_count[hit] = '0;
            end else begin
                slot_count[hit] = slot_count[hit] - 16'd1;
                res.conn_count  = slot_count[hit];
            end
        end else begin
            if (hit < 0) res.status = ST_NOT_FOUND;
            else res.conn_count = slot_count[hit];
        end
        res.over_limit = (res.conn_count > limit_shadow);
        return res;
    endfunction

    // Offers one beat and returns at the falling edge after it was taken,
    // with tvalid still high so that a following beat can go out back to back.
    task automatic send_op(input logic [1:0] func, input logic [31:0] addr);
        int gap;
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            in_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_tvalid = 1'b1;
        in_tdata  = addr;
        in_tuser  = func;
        do @(posedge clk); while (!in_tready);
        pending_results.push_back(predict_conn_result(func, addr));
        @(negedge clk);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        in_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        limit_shadow = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic test_nil_address();
        send_op(FUNC_OPEN, 32'd0);
        send_op(FUNC_CLOSE, 32'd0);
        send_op(FUNC_QUERY, 32'd0);
        send_op(FUNC_SPARE, 32'd0);
    endtask

    // Open up to the limit, get refused, then close down until the slot is freed.
    task automatic test_open_close_cycle();
        write_limit(16'd3);
        repeat (4) send_op(FUNC_OPEN, 32'h0A00_0001);
        send_op(FUNC_QUERY, 32'h0A00_0001);
        send_op(FUNC_SPARE, 32'h0A00_0001);
        repeat (3) send_op(FUNC_CLOSE, 32'h0A00_0001);
        send_op(FUNC_CLOSE, 32'h0A00_0001);
        send_op(FUNC_QUERY, 32'h0A00_0001);
    endtask

    // With a limit of zero a new address still gets in, already over the limit.
    task automatic test_zero_limit();
        write_limit(16'd0);
        send_op(FUNC_OPEN, 32'hFFFF_FFFF);
        send_op(FUNC_OPEN, 32'hFFFF_FFFF);
        send_op(FUNC_CLOSE, 32'hFFFF_FFFF);
    endtask

    // Lowering the limit below a live count shows the over-limit flag.
    task automatic test_lowered_limit();
        write_limit(16'd5);
        repeat (4) send_op(FUNC_OPEN, 32'h0000_0001);
        write_limit(16'd2);
        send_op(FUNC_QUERY, 32'h0000_0001);
        send_op(FUNC_OPEN, 32'h0000_0001);
        send_op(FUNC_CLOSE, 32'h0000_0001);
        write_limit(16'hFFFF);
        repeat (3) send_op(FUNC_OPEN, 32'h8000_0000);
        send_op(FUNC_QUERY, 32'h8000_0000);
        repeat (4) send_op(FUNC_CLOSE, 32'h8000_0000);
        repeat (2) send_op(FUNC_CLOSE, 32'h0000_0001);
    endtask

    // Fill every slot, then one more new address must be turned away.
    task automatic test_table_full();
        write_limit(16'd1);
        for (int i = 0; i < TABLE_SLOTS; i++) send_op(FUNC_OPEN, 32'hC0A8_0100 + i);
        send_op(FUNC_OPEN, 32'h5555_AAAA);
        send_op(FUNC_OPEN, 32'hC0A8_0105);
        send_op(FUNC_QUERY, 32'h5555_AAAA);
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) send_op(FUNC_CLOSE, 32'hC0A8_0100 + i);
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_output_backpressure();
        wait_drained();
        write_limit(16'd8);
        receiver_hold = 300;
        repeat (10) send_op(FUNC_OPEN, 32'h1234_5678);
        repeat (10) send_op(FUNC_CLOSE, 32'h1234_5678);
        wait_drained();
    endtask

    // Random operations over a pool of addresses so that most of them hit
    // live entries; a few nil and never-seen addresses mix in.
    task automatic test_random_traffic(input int n_items, input int pool_size);
        int          pick;
        logic [1:0]  func;
        logic [31:0] addr;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) func = FUNC_OPEN;
            else if (pick < 75) func = FUNC_CLOSE;
            else if (pick < 95) func = FUNC_QUERY;
            else func = FUNC_SPARE;
            pick = $urandom_range(0, 99);
            if (pick < 4) addr = 32'd0;
            else if (pick < 10) addr = $urandom;
            else addr = addr_pool[$urandom_range(0, pool_size - 1)];
            send_op(func, addr);
            if ($urandom_range(0, 59) == 0) wait_drained();
        end
    endtask

    // Receiver side: long hold-offs on request, random stall bursts otherwise.
    initial begin
        out_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (receiver_hold > 0) begin
                out_tready = 1'b0;
                receiver_hold--;
            end else if (receiver_burst > 0) begin
                out_tready = 1'b0;
                receiver_burst--;
            end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
                out_tready = 1'b0;
                receiver_burst = $urandom_range(1, 14) - 1;
            end else begin
                out_tready = 1'b1;
            end
        end
    end

    // Result checker: every beat taken is matched with the oldest expectation.
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_tvalid && out_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation waiting");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_tuser[2:0] !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, out_tuser[2:0]);
                    error_count++;
                end
                if (out_tdata !== want.conn_count) begin
                    $error("conn_count expected %0d actual %0d", want.conn_count, out_tdata);
                    error_count++;
                end
                if (out_tuser[3] !== want.over_limit) begin
                    $error("over_limit expected %0d actual %0d", want.over_limit, out_tuser[3]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk) begin
        if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        rst_n            = 1'b0;
        in_tvalid        = 1'b0;
        in_tdata         = '0;
        in_tuser         = '0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        error_count      = 0;
        quiet_cycles     = 0;
        receiver_hold    = 0;
        receiver_burst   = 0;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        limit_shadow     = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_addr[i]  = '0;
            slot_count[i] = '0;
        end
        addr_pool[0] = 32'hFFFF_FFFF;
        addr_pool[1] = 32'h0000_0001;
        addr_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_MAX; i++) begin
            addr_pool[i] = $urandom;
            if (addr_pool[i] == 32'd0) addr_pool[i] = 32'h7F00_0001;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_nil_address();
        test_open_close_cycle();
        test_zero_limit();
        test_lowered_limit();
        test_table_full();
        test_output_backpressure();

        write_limit(16'd2);
        test_random_traffic(100, 6);
        write_limit(16'd0);
        test_random_traffic(80, 10);
        write_limit(16'hFFFF);
        test_random_traffic(60, 8);
        write_limit(16'd1);
        test_random_traffic(100, 90);
        write_limit(16'($urandom_range(3, 6)));
        test_random_traffic(60, 5);
        write_limit(16'($urandom));
        test_random_traffic(100, 80);
        write_limit(16'd4);
        test_random_traffic(40, 12);

        // Last stretch runs with both sides always ready.
        wait_drained();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        write_limit(16'd3);
        test_random_traffic(80, 7);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pcl_pkg.sv
rtl/pcl_ram.sv
rtl/pcl_ctrl.sv
rtl/per_source_connection_limiter_top.sv
bench/tb_per_source_connection_limiter_top.sv
